// ===== hdl/sdti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdti_pkg: shared types and constants
// Transaction payload structs and status codes for the converter.
// ----------------------------------------------------------------------------
package sdti_pkg;

   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_OVF = 2'd1;
   localparam logic [1:0] STATUS_NAN = 2'd2;

   // Byte address of the divisor exponent register.
   localparam logic [1:0] ADDR_DIVISOR_EXP = 2'd0;

   localparam logic [63:0] INT64_MAX_BITS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] INT64_MIN_BITS = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [63:0] value_bits;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic signed [63:0] int_value;
      logic [1:0]         status;
      logic               last_out;
   } rsp_type;

   // Decoded operand handed from the unpack stage to the shift stage.
   typedef struct packed {
      logic               neg;
      logic               is_nan;
      logic               is_inf;
      logic               is_zero;
      logic [52:0]        mant;
      logic signed [12:0] t;
      logic               last;
   } dec_type;

   // Rounded magnitude handed from the shift stage to the output stage.
   typedef struct packed {
      logic        neg;
      logic        is_nan;
      logic        ovf;
      logic [63:0] mag;
      logic        last;
   } mag_type;

endpackage

// ===== hdl/sdti_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdti_decode: field unpack stage
// Splits the binary64 pattern and computes the net shift amount.
// ----------------------------------------------------------------------------
module sdti_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  sdti_pkg::req_type     in_data,
   input  logic signed [10:0]    divisor_exponent,
   output logic                  out_valid,
   output sdti_pkg::dec_type     out_data
);
   import sdti_pkg::*;

   logic [10:0]        expf;
   logic [51:0]        frac;
   logic signed [12:0] scale;
   dec_type            dec_in;
   dec_type            dec_ff;
   logic               valid_ff;

   always_comb begin
      expf           = in_data.value_bits[62:52];
      frac           = in_data.value_bits[51:0];
      scale          = (expf == 11'd0) ? -13'sd1074
                                       : $signed({2'b00, expf}) - 13'sd1075;
      dec_in.neg     = in_data.value_bits[63];
      dec_in.is_nan  = (expf == 11'h7FF) && (frac != 52'd0);
      dec_in.is_inf  = (expf == 11'h7FF) && (frac == 52'd0);
      dec_in.mant    = {(expf != 11'd0), frac};
      dec_in.is_zero = (expf == 11'd0) && (frac == 52'd0);
      dec_in.t       = scale - {{2{divisor_exponent[10]}}, divisor_exponent};
      dec_in.last    = in_data.last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      dec_ff <= dec_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = dec_ff;
endmodule

// ===== hdl/sdti_shift.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdti_shift: align and round stage
// Shifts the significand by the net exponent and rounds to nearest even.
// ----------------------------------------------------------------------------
module sdti_shift (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  sdti_pkg::dec_type  in_data,
   output logic               out_valid,
   output sdti_pkg::mag_type  out_data
);
   import sdti_pkg::*;

   logic [6:0]   lz;
   logic [116:0] wide;
   logic [5:0]   n;
   logic [52:0]  q;
   logic [52:0]  rem;
   logic [52:0]  half;
   logic [53:0]  qr;
   mag_type      mag_in;
   mag_type      mag_ff;
   logic         valid_ff;

   // Position of the leading one gives the significand length.
   always_comb begin
      lz = 7'd53;
      for (int i = 0; i < 53; i++) begin
         if (in_data.mant[i]) lz = 7'(52 - i);
      end
   end

   always_comb begin
      wide         = '0;
      n            = '0;
      q            = '0;
      rem          = '0;
      half         = '0;
      qr           = '0;
      mag_in.neg   = in_data.neg;
      mag_in.is_nan = in_data.is_nan;
      mag_in.last  = in_data.last;
      mag_in.ovf   = in_data.is_inf;
      mag_in.mag   = '0;
      if (in_data.is_nan || in_data.is_inf || in_data.is_zero) begin
         mag_in.mag = '0;
      end else if (!in_data.t[12]) begin
         // Left shift: overflow when length + t exceeds 64.
         if (in_data.t > 13'sd64 ||
             ($signed({6'd0, 7'd53 - lz}) + in_data.t) > 13'sd64) begin
            mag_in.ovf = 1'b1;
         end else begin
            wide       = {64'd0, in_data.mant} << in_data.t[6:0];
            mag_in.mag = wide[63:0];
         end
      end else if (in_data.t <= -13'sd54) begin
         mag_in.mag = '0;
      end else begin
         n    = 6'(-in_data.t);
         q    = in_data.mant >> n;
         rem  = in_data.mant & ((53'd1 << n) - 53'd1);
         half = 53'd1 << (n - 6'd1);
         qr   = {1'b0, q};
         if (rem > half || (rem == half && q[0])) qr = qr + 54'd1;
         mag_in.mag = {10'd0, qr};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      mag_ff <= mag_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = mag_ff;
endmodule

// ===== hdl/sdti_pack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdti_pack: range check and sign stage
// Saturates out-of-range magnitudes and applies the sign.
// ----------------------------------------------------------------------------
module sdti_pack (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  sdti_pkg::mag_type  in_data,
   output logic               out_valid,
   output sdti_pkg::rsp_type  out_data
);
   import sdti_pkg::*;

   logic    ovf;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    valid_ff;

   always_comb begin
      ovf = in_data.ovf ||
            (in_data.neg ? (in_data.mag > INT64_MIN_BITS) : (in_data.mag > INT64_MAX_BITS));
      rsp_in.last_out = in_data.last;
      if (in_data.is_nan) begin
         rsp_in.int_value = '0;
         rsp_in.status    = STATUS_NAN;
      end else if (ovf) begin
         rsp_in.int_value = in_data.neg ? INT64_MIN_BITS : INT64_MAX_BITS;
         rsp_in.status    = STATUS_OVF;
      end else begin
         rsp_in.int_value = in_data.neg ? (64'd0 - in_data.mag) : in_data.mag;
         rsp_in.status    = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;
endmodule

// ===== hdl/scaled_double_to_int64_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_double_to_int64_round: scaled binary64 to int64 converter
// Divides a double by a configured power of two and rounds to nearest even.
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   -------   ---------------------   -----------------------------
//   request   start / busy            req_data (value_bits, last_in)
//   response  rsp_valid strobe        rsp_data (int_value, status, last_out)
//   csr       APB psel/penable/...    divisor_exponent at address 0
//
// Every transaction passes the registered stages from start to the rsp_valid
// strobe: unpack, align/round, then saturate/sign. A new transaction is accepted in
// every cycle, so busy is held low. Reset clears the stage valid bits and
// sets divisor_exponent to zero. The receiver cannot stall, so the pipeline
// never holds and no result is lost or repeated.
// ----------------------------------------------------------------------------
module scaled_double_to_int64_round (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  sdti_pkg::req_type   req_data,
   output logic                rsp_valid,
   output sdti_pkg::rsp_type   rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [1:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import sdti_pkg::*;

   logic signed [10:0] div_exp_ff;
   logic               dec_valid;
   dec_type            dec_data;
   logic               mag_valid;
   mag_type            mag_data;
   logic               accept;

   // Nothing back-pressures the pipeline, so requests are always taken.
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign pready = 1'b1;

   // The single register sits at byte address 0; other writes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         div_exp_ff <= '0;
      end else if (psel && penable && pwrite && pready && paddr == ADDR_DIVISOR_EXP) begin
         div_exp_ff <= pwdata[10:0];
      end
   end

   assign prdata = (paddr == ADDR_DIVISOR_EXP) ? {{21{div_exp_ff[10]}}, div_exp_ff} : 32'd0;

   sdti_decode u_decode (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (accept),
      .in_data          (req_data),
      .divisor_exponent (div_exp_ff),
      .out_valid        (dec_valid),
      .out_data         (dec_data)
   );

   sdti_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_data   (dec_data),
      .out_valid (mag_valid),
      .out_data  (mag_data)
   );

   sdti_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mag_valid),
      .in_data   (mag_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

`ifndef SYNTH
   // Each accepted transaction yields a result strobe after the decode, shift and pack registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid) else $error("result strobe missing");
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 3)) else $error("unexpected result strobe");
   a_nan_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_NAN) |-> rsp_data.int_value == 64'd0)
      else $error("NaN result not zero");
`endif
endmodule

// ===== sim/sdti_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdti_checker: response checker for the scaled double to int64 converter
// Watches the request, response and register ports, predicts each result
// with its own conversion model and compares it field by field.
// ----------------------------------------------------------------------------
module sdti_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  sdti_pkg::req_type   req_data,
   input  logic                rsp_valid,
   input  sdti_pkg::rsp_type   rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [1:0]          paddr,
   input  logic [31:0]         pwdata,
   input  logic                pready,
   output int                  fail_count,
   output int                  pending_count
);
   import sdti_pkg::*;

   logic signed [10:0] div_exp;
   rsp_type            expected_q[$];

   function automatic rsp_type convert_scaled(input req_type r,
                                              input logic signed [10:0] de);
      rsp_type     o;
      logic        neg;
      logic [10:0] ef;
      logic [51:0] fr;
      logic [52:0] mant;
      logic [63:0] mag, q, rem, half;
      logic        ovf;
      int          scale, t, n, len;
      neg = r.value_bits[63];
      ef = r.value_bits[62:52];
      fr = r.value_bits[51:0];
      o.last_out = r.last_in;
      mag = '0;
      ovf = 1'b0;
      if (ef == 11'h7FF) begin
         o.int_value = (fr != 0) ? 64'd0 : (neg ? INT64_MIN_BITS : INT64_MAX_BITS);
         o.status = (fr != 0) ? STATUS_NAN : STATUS_OVF;
         return o;
      end
      if (ef == 0) begin
         mant = {1'b0, fr};
         scale = -1074;
      end else begin
         mant = {1'b1, fr};
         scale = int'(ef) - 1075;
      end
      t = scale - int'(de);
      if (mant == 0) begin
         mag = '0;
      end else if (t >= 0) begin
         len = 0;
         for (int i = 0; i < 53; i++)
            if (mant[i]) len = i + 1;
         if (len + t > 64) ovf = 1'b1;
         else mag = 64'(mant) << t;
      end else begin
         n = -t;
         if (n < 54) begin
            q = 64'(mant) >> n;
            rem = 64'(mant) & ((64'd1 << n) - 64'd1);
            half = 64'd1 << (n - 1);
            if (rem > half || (rem == half && q[0])) q = q + 64'd1;
            mag = q;
         end
      end
      if (!ovf && (neg ? (mag > INT64_MIN_BITS) : (mag > INT64_MAX_BITS)))
         ovf = 1'b1;
      if (ovf) begin
         o.int_value = neg ? INT64_MIN_BITS : INT64_MAX_BITS;
         o.status = STATUS_OVF;
      end else begin
         o.int_value = neg ? (64'd0 - mag) : mag;
         o.status = STATUS_OK;
      end
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         div_exp <= '0;
         fail_count = 0;
         expected_q.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_data.int_value, 64'd0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.int_value !== want.int_value)
                  report_mismatch("int_value", rsp_data.int_value, want.int_value);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.last_out !== want.last_out)
                  report_mismatch("last_out", 64'(rsp_data.last_out), 64'(want.last_out));
            end
         end
         if (start && !busy)
            expected_q.push_back(convert_scaled(req_data, div_exp));
         if (psel && penable && pwrite && pready && paddr == ADDR_DIVISOR_EXP)
            div_exp <= pwdata[10:0];
      end
   end
endmodule

// ===== sim/scaled_double_to_int64_round_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_double_to_int64_round_tb: testbench top for the converter
// Drives directed and random doubles under several divisor settings; the
// checker predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module scaled_double_to_int64_round_tb;
   import sdti_pkg::*;

   localparam int         CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;

   always #2 clock = ~clock;

   scaled_double_to_int64_round u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   sdti_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .fail_count(fail_count),
      .pending_count(pending_count)
   );

   // The watchdog ends a hung run; the budget is far above the slowest
   // correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Register write: setup phase then access phase, waiting on pready.
   task automatic write_divisor(input logic signed [10:0] de);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_DIVISOR_EXP;
      pwdata <= {{21{de[10]}}, de};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly short gaps, now and then a long one, sometimes none at all.
   // With no gap, start is left alone so the next item follows directly.
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // One request transaction; start stays high through back-to-back items
   // and is lowered only when a gap follows.
   task automatic send_value(input logic [63:0] bits, input logic last);
      start <= 1'b1;
      req_data <= '{value_bits: bits, last_in: last};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Wait until every expected result has come, then let the pipeline drain.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Random doubles whose exponent lies near the interesting window for the
   // current divisor, so rounding, ties and saturation are all reached.
   function automatic logic [63:0] random_double(input logic signed [10:0] de);
      logic [63:0] b;
      int          e;
      b = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: ;  // fully random pattern
         1: b[62:52] = ($urandom_range(0, 1)) ? 11'h7FF : 11'h000;
         2: b[51:0] = 52'(1) << $urandom_range(0, 51);  // likely ties
         default: begin
            e = 1075 + int'(de) + $signed($urandom_range(0, 120)) - 56;
            if (e < 1) e = 1;
            if (e > 2046) e = 2046;
            b[62:52] = e[10:0];
            if ($urandom_range(0, 3) == 0) b[31:0] = '0;
         end
      endcase
      return b;
   endfunction

   initial begin
      logic signed [10:0] settings[6];
      logic signed [10:0] de;
      settings = '{11'sd0, -11'sd1024, 11'sd1023, 11'sd10, -11'sd30, 11'sd52};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed transactions with the reset divisor: the special cases.
      send_value(64'h7FF8_0000_0000_0000, 1'b0);  // quiet NaN
      send_value(64'hFFF0_0000_0000_0001, 1'b1);  // signalling NaN, negative
      send_value(64'h7FF0_0000_0000_0000, 1'b0);  // +infinity
      send_value(64'hFFF0_0000_0000_0000, 1'b0);  // -infinity
      send_value(64'h0000_0000_0000_0000, 1'b0);  // +0
      send_value(64'h8000_0000_0000_0000, 1'b1);  // -0
      send_value(64'h0000_0000_0000_0001, 1'b0);  // smallest subnormal
      send_value(64'h800F_FFFF_FFFF_FFFF, 1'b0);  // largest-magnitude subnormal, negative
      send_value(64'h3FE0_0000_0000_0000, 1'b0);  // 0.5 ties to 0
      send_value(64'h3FF8_0000_0000_0000, 1'b0);  // 1.5 ties to 2
      send_value(64'hC004_0000_0000_0000, 1'b0);  // -2.5 ties to -2
      send_value(64'h3FDF_FFFF_FFFF_FFFF, 1'b0);  // just under one half
      send_value(64'hC3E0_0000_0000_0000, 1'b0);  // exactly -2^63
      send_value(64'h43E0_0000_0000_0000, 1'b0);  // 2^63 overflows
      send_value(64'h43DF_FFFF_FFFF_FFFF, 1'b0);  // largest in range
      send_value(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);  // largest finite
      send_value(64'hFFEF_FFFF_FFFF_FFFF, 1'b1);  // most negative finite
      send_value(64'h3FF0_0000_0000_0000, 1'b0);  // 1.0
      drain();

      // Extreme divisors exercised with subnormals and large values.
      write_divisor(-11'sd1024);
      send_value(64'h0000_0000_0000_0001, 1'b0);
      send_value(64'h0000_0000_0000_0000, 1'b0);
      send_value(64'h800F_FFFF_FFFF_FFFF, 1'b1);
      drain();
      write_divisor(11'sd1023);
      send_value(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
      send_value(64'h7FE0_0000_0000_0000, 1'b1);
      drain();

      // Random phases, each under its own divisor setting.
      for (int p = 0; p < 8; p++) begin
         de = (p < 6) ? settings[p] : 11'($urandom_range(0, 2047));
         write_divisor(de);
         for (int i = 0; i < 50; i++) begin
            send_value(random_double(de), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) == 0) idle_gap();
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

// ===== files.f =====
hdl/sdti_pkg.sv
hdl/sdti_decode.sv
hdl/sdti_shift.sv
hdl/sdti_pack.sv
hdl/scaled_double_to_int64_round.sv
sim/sdti_checker.sv
sim/scaled_double_to_int64_round_tb.sv
